// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/cpo_pkg.sv
// Package with types, constants and the sine table function of the oscillator step core.
`timescale 1ns / 1ps
`default_nettype none
package cpo_pkg;
  localparam int unsigned MAX_OSC_C = 16;
  localparam int unsigned SINE_BITS_C = 8;
  localparam int unsigned SINE_DEPTH_C = 1 << SINE_BITS_C;
  localparam logic [21:0] RAD_TO_TURN = 22'd2670177;

  typedef enum logic [1:0] {
    OP_COUPLING = 2'd0,
    OP_PHASE    = 2'd1,
    OP_STEP     = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_DT    = 2'd1,
    CFG_RUN   = 2'd2,
    CFG_LOCK  = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DERIV,
    ST_UPDATE,
    ST_COH,
    ST_ROOT,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Control handed from the sequencer to each cell.
  typedef struct packed {
    logic load;     // load phase at load_slot
    logic shift;    // rotate phases along the chain
    logic add;      // add increment to head phase while rotating
  } cell_ctl_t;

  // Sine table entry in Q1.15, built once from a Taylor series over a quadrant.
  function automatic logic signed [16:0] sine_entry(input int unsigned k);
    longint unsigned m, quad, r, x, term, recip;
    logic [127:0] prod;
    longint s;
    longint v;
    m = 4 * longint'(k);
    quad = m >> SINE_BITS_C;
    r = m & 64'(SINE_DEPTH_C - 1);
    if (quad[0]) r = 64'(SINE_DEPTH_C) - r;
    x = (64'd1686629714 * r) >> SINE_BITS_C;
    s = longint'(x);
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      // The term stays below 2^32, so a 2^40 reciprocal gives the exact floor
      // of the division by (2n)(2n+1).
      case (n)
        1: recip = 64'd183251937963;
        2: recip = 64'd54975581389;
        3: recip = 64'd26178848281;
        4: recip = 64'd15270994831;
        5: recip = 64'd9995560253;
        6: recip = 64'd7048151461;
        default: recip = 64'd5235769657;
      endcase
      prod = 128'(term) * 128'(recip);
      term = 64'(prod >> 40);
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    v = (s + 16384) >>> 15;
    if (quad[1]) v = -v;
    return 17'(v);
  endfunction
endpackage
`default_nettype wire

// File: sv/coupled_phase_oscillator_step_core.sv
// Top level of the coupled phase oscillator step core.
`timescale 1ns / 1ps
`default_nettype none
// Fixed-point Euler step of the Kuramoto model for up to MAX_OSC oscillators.
// Phases sit in a chain of cells that rotates by one place a cycle; the
// coupling matrix sits in a memory with one read port. A coupling write sets
// both mirrored entries, one after the other, and the input is not ready
// while the mirrored entry is written. With phase lock on, a step runs the
// single sine-multiply-accumulate unit (one coupling term a cycle, reading the
// coupling memory and the sine table), then the phase update (a multiply
// lead-in, then one full lap of the whole chain) and, with two or more
// oscillators, the cosine/sine sums, a bit-pair square root and a restoring
// divide. With phase lock off the step goes straight to its results. The n
// results then leave through a registered output stage, at most one a cycle
// and a new one only once the previous one has been taken; the input is not
// ready until the last result has been loaded into that stage.
// After reset the coupling memory is cleared by a pass over all
// MAX_OSC*MAX_OSC entries, during which no request is taken.
module coupled_phase_oscillator_step_core
  import cpo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: first_slot[3:0], second_slot[7:4], coupling_value[23:8], phase_value[39:24]
  input  wire logic [39:0] s_tdata,
  // tuser: opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: osc_slot[3:0], new_phase[19:4], coherence[35:20], zero fill [39:36]
  output logic [39:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int unsigned MAX_OSC = MAX_OSC_C;
  localparam int unsigned IW = $clog2(MAX_OSC);
  localparam int unsigned CW = $clog2(MAX_OSC + 1);
  localparam int unsigned MW = 2 * IW;
  localparam int unsigned TW = SINE_BITS_C;
  localparam int unsigned DEPTH = MAX_OSC * MAX_OSC;

  logic signed [16:0] sine_rom [SINE_DEPTH_C];
  for (genvar k = 0; k < SINE_DEPTH_C; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  // Configuration registers.
  logic [4:0]  osc_count;
  logic [15:0] time_step;
  logic        running, lock_en;
  always_ff @(posedge clk) begin
    if (rst) begin
      osc_count <= '0; time_step <= 16'd256; running <= 1'b0; lock_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT: osc_count <= cfg_data[4:0];
        CFG_DT:    time_step <= cfg_data;
        CFG_RUN:   running <= cfg_data[0];
        CFG_LOCK:  lock_en <= cfg_data[0];
        default:   ;
      endcase
    end
  end
  logic [CW-1:0] n;
  assign n = (32'(osc_count) > MAX_OSC) ? CW'(MAX_OSC) : CW'(osc_count);

  // Input fields.
  opcode_t opcode;
  logic [3:0] slot_a, slot_b;
  logic [15:0] cval, pval;
  assign opcode = opcode_t'(s_tuser);
  assign slot_a = s_tdata[3:0];
  assign slot_b = s_tdata[7:4];
  assign cval = s_tdata[23:8];
  assign pval = s_tdata[39:24];

  state_t state, state_next;
  logic accept;
  assign accept = s_tvalid && s_tready;

  // Phase chain: cell k holds phase of oscillator (k + shifts) mod MAX_OSC during
  // rotation; every rotation is a full lap, so at rest cell k holds oscillator k.
  cell_ctl_t ctl;
  logic [15:0] ph [MAX_OSC];
  logic [15:0] head_in;
  logic [IW-1:0] load_slot;
  logic [15:0] inc;
  for (genvar k = 0; k < MAX_OSC; k++) begin : g_cell
    logic [15:0] prv;
    if (k == MAX_OSC - 1) begin : g_tail
      assign prv = head_in;
    end else begin : g_mid
      assign prv = ph[k+1];
    end
    cpo_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .sel(load_slot == IW'(k)),
      .load_value(pval), .prev_phase(prv), .phase(ph[k])
    );
  end

  // Rotation over all MAX_OSC cells: the value leaving cell 0 reenters at the
  // last cell, with its increment added when it belongs to an oscillator in use.
  // Unused cells rotate too and come back unchanged after the lap.
  assign head_in = ctl.add ? (ph[0] + inc) : ph[0];

  // Coupling memory.
  logic [15:0] cmem [DEPTH];
  logic        cm_we;
  logic [MW-1:0] cm_wa, cm_ra;
  logic [15:0] cm_wd, cm_rd;
  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_wa] <= cm_wd;
    cm_rd <= cmem[cm_ra];
  end

  // Counters.
  logic [MW:0]   clr_cnt;
  logic [IW:0]   ci, cj;     // derivative loop indices
  logic [IW:0]   rot;        // rotation count
  logic          mirror;     // second half of a coupling write
  logic [3:0]    wa, wb;
  logic [15:0]   wv;
  logic [5:0]    step_cnt;
  logic [IW:0]   emit_i;

  // Derivative pipeline: phases are read from the chain by index (a small mux row).
  logic [15:0] pi_q, pj_q, diff;
  logic        mac_v, mac_skip;
  logic signed [16:0] sin_q;
  logic signed [40:0] acc;
  logic signed [23:0] deriv [MAX_OSC];
  logic [IW-1:0] mac_i;
  logic mac_lastj;

  // Update and coherence.
  logic signed [39:0] dprod;
  logic signed [63:0] iprod;
  logic signed [21:0] csum, ssum;
  logic [43:0] rad;
  logic [22:0] root;
  logic [43:0] rem_sq;
  logic [15:0] quo;
  logic [22:0] drem;
  logic [15:0] coh;

  // Output stage.
  logic [39:0] out_data;
  logic        out_last, out_valid;
  assign m_tvalid = out_valid;
  assign m_tdata = out_data;
  assign m_tlast = out_last;
  logic emit_go;
  assign emit_go = (state == ST_EMIT) && (!out_valid || m_tready);

  // The mirrored coupling entry owns the write port for one cycle.
  assign s_tready = (state == ST_IDLE) && !mirror;

  // The coupling term of row ci, column cj is read while its sine is looked up.
  assign cm_ra = {ci[IW-1:0], cj[IW-1:0]};

  always_comb begin
    state_next = state;
    ctl = '0;
    load_slot = slot_a[IW-1:0];
    cm_we = 1'b0;
    cm_wa = '0;
    cm_wd = '0;
    case (state)
      ST_CLEAR: begin
        cm_we = 1'b1;
        cm_wa = clr_cnt[MW-1:0];
        if (clr_cnt == (MW+1)'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (mirror) begin
          cm_we = 1'b1;
          cm_wa = {wb[IW-1:0], wa[IW-1:0]};
          cm_wd = wv;
        end
        if (accept) begin
          case (opcode)
            OP_COUPLING: begin
              if (CW'(slot_a) < n && CW'(slot_b) < n) begin
                cm_we = 1'b1;
                cm_wa = {slot_a[IW-1:0], slot_b[IW-1:0]};
                cm_wd = cval;
              end
            end
            OP_PHASE: ctl.load = (32'(slot_a) < MAX_OSC);
            OP_STEP: begin
              if (running && n != '0) state_next = lock_en ? ST_DERIV : ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_DERIV: if (mac_v && mac_lastj && CW'(mac_i) == n - 1'b1) state_next = ST_UPDATE;
      ST_UPDATE: begin
        ctl.shift = (32'(rot) >= 2) && (32'(rot) < MAX_OSC + 2);
        ctl.add = ctl.shift && (32'(rot) < 32'(n) + 2);
        if (32'(rot) == MAX_OSC + 2) begin
          state_next = (n >= 2) ? ST_COH : ST_EMIT;
        end
      end
      ST_COH: if (32'(rot) == 32'(n) + 1) state_next = ST_ROOT;
      ST_ROOT: if (step_cnt == 6'd22) state_next = ST_DIV;
      ST_DIV: if (step_cnt == 6'd23) state_next = ST_EMIT;
      ST_EMIT: if (emit_go && CW'(emit_i) == n - 1'b1) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // The update rotation uses a pipeline: increment for the head cell is computed
  // ahead, through dprod and iprod, from deriv of the oscillator that reaches the head.
  // To keep it simple, rotation stalls (shift=0) while that pipeline fills.
  logic [IW:0] upd_idx;
  assign upd_idx = rot;

  assign pi_q = ph[ci[IW-1:0]];
  assign pj_q = ph[cj[IW-1:0]];
  assign diff = pj_q - pi_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      mirror <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      mirror <= accept && opcode == OP_COUPLING &&
                CW'(slot_a) < n && CW'(slot_b) < n;
      if (emit_go) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    wa <= slot_a; wb <= slot_b; wv <= cval;
    mac_v <= 1'b0;
    case (state)
      ST_IDLE: begin
        ci <= '0; cj <= '0; rot <= '0; step_cnt <= '0; emit_i <= '0;
        acc <= '0; coh <= '0;
        csum <= '0; ssum <= '0;
      end
      ST_DERIV: begin
        if (32'(ci) < 32'(n)) begin
          mac_v <= 1'b1;
          mac_skip <= (ci == cj);
          mac_i <= ci[IW-1:0];
          mac_lastj <= (cj == (IW+1)'(n - 1'b1));
          sin_q <= sine_rom[diff[15 -: TW]];
          if (cj == (IW+1)'(n - 1'b1)) begin
            cj <= '0; ci <= ci + 1'b1;
          end else begin
            cj <= cj + 1'b1;
          end
        end
        // Coupling and sine of the term issued last cycle are both registered now.
        if (mac_v) begin
          if (mac_lastj) begin
            deriv[mac_i] <= 24'((acc + (mac_skip ? 41'sd0 :
                            41'($signed(cm_rd)) * 41'(sin_q))) >>> 15);
            acc <= '0;
          end else if (!mac_skip) begin
            acc <= acc + 41'($signed(cm_rd)) * 41'(sin_q);
          end
        end
      end
      ST_UPDATE: begin
        // The derivative is multiplied by dt into dprod, scaled into iprod, then the chain rotates.
        if (32'(rot) < MAX_OSC + 2) rot <= rot + 1'b1;
        else rot <= '0;
        dprod <= deriv[upd_idx[IW-1:0]] * $signed({1'b0, time_step});
        iprod <= 64'(dprod) * $signed({1'b0, RAD_TO_TURN}) + 64'sd2147483648;
      end
      ST_COH: begin
        rot <= rot + 1'b1;
        if (32'(rot) < 32'(n)) begin
          csum <= csum + 22'(sine_rom[TW'((ph[rot[IW-1:0]] + 16'd16384) >> (16 - TW))]);
          ssum <= ssum + 22'(sine_rom[ph[rot[IW-1:0]][15 -: TW]]);
        end
        rad <= 44'($signed(csum) * $signed(csum)) + 44'($signed(ssum) * $signed(ssum));
        root <= '0; rem_sq <= '0;
      end
      ST_ROOT: begin
        // Two radicand bits a cycle.
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt < 6'd22) begin
          rem_sq <= ({rem_sq[41:0], rad[43:42]} >= {root[20:0], 2'b01}) ?
                    {rem_sq[41:0], rad[43:42]} - 44'({root[20:0], 2'b01}) :
                    {rem_sq[41:0], rad[43:42]};
          root <= {root[21:0], ({rem_sq[41:0], rad[43:42]} >= {root[20:0], 2'b01})};
          rad <= {rad[41:0], 2'b00};
        end else begin
          step_cnt <= '0; drem <= '0; quo <= '0;
        end
      end
      ST_DIV: begin
        // One root bit a cycle, all 23 of them; the quotient fits in 16 bits.
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt < 6'd23) begin
          if ({drem[21:0], root[22]} >= 23'(n)) begin
            drem <= {drem[21:0], root[22]} - 23'(n);
            quo <= {quo[14:0], 1'b1};
          end else begin
            drem <= {drem[21:0], root[22]};
            quo <= {quo[14:0], 1'b0};
          end
          root <= {root[21:0], 1'b0};
        end
        coh <= quo;
      end
      ST_EMIT: begin
        if (emit_go) begin
          emit_i <= emit_i + 1'b1;
          out_data <= {4'b0,
                       (CW'(emit_i) == n - 1'b1) ? coh : 16'd0,
                       ph[emit_i[IW-1:0]], 4'(emit_i)};
          out_last <= (CW'(emit_i) == n - 1'b1);
        end
      end
      default: ;
    endcase
  end
  assign inc = iprod[47:32];

  `include "assert_macros.svh"
  `CHK_IMPLY(a_idle_ready, clk, rst, s_tready, state == ST_IDLE, "ready outside idle")
  `CHK_NEXT(a_emit_valid, clk, rst, emit_go, m_tvalid, "emitted result not valid")
  `CHK_IMPLY(a_last_valid, clk, rst, m_tlast && m_tvalid, m_tdata[39:36] == 4'd0, "fill bits set")
endmodule
`default_nettype wire

// File: sv/cpo_cell.sv
// One cell of the phase chain: holds one phase and passes it to its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module cpo_cell
  import cpo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cell_ctl_t   ctl,
  input  wire logic        sel,
  input  wire logic [15:0] load_value,
  input  wire logic [15:0] prev_phase,
  output logic [15:0]      phase
);
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctl.load && sel) begin
      phase <= load_value;
    end else if (ctl.shift) begin
      phase <= prev_phase;
    end
  end
endmodule
`default_nettype wire

// File: test/coupled_phase_oscillator_step_checker.sv
// Checker that predicts and compares the results of the oscillator step core.
`timescale 1ns / 1ps
module coupled_phase_oscillator_step_checker
  import cpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          failures,
  output int          pending
);
  typedef struct {
    logic [3:0]  slot;
    logic [15:0] phase;
    logic [15:0] coh;
    logic        last;
  } osc_report_t;

  osc_report_t report_queue[$];
  logic signed [16:0] sine_lut[SINE_DEPTH_C];
  logic [15:0] phase_mem[MAX_OSC_C];
  logic [15:0] coupling_mem[MAX_OSC_C * MAX_OSC_C];
  logic [4:0]  osc_count;
  logic [15:0] dt;
  logic        run_on;
  logic        lock_on;

  // Taylor series of sine over one quadrant in Q30, rounded to Q1.15.
  function automatic logic signed [16:0] quarter_sine(input int unsigned k);
    longint unsigned m, quad, r, x, term;
    longint s;
    m = 4 * longint'(k);
    quad = m / SINE_DEPTH_C;
    r = m - quad * SINE_DEPTH_C;
    if (quad[0]) r = SINE_DEPTH_C - r;
    x = (64'd1686629714 * r) / SINE_DEPTH_C;
    s = longint'(x);
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      s = (n % 2 == 1) ? s - longint'(term) : s + longint'(term);
    end
    if (s < 0) s = 0;
    s = (s + 16384) >>> 15;
    return quad[1] ? 17'(-s) : 17'(s);
  endfunction

  function automatic longint sine_at(input logic [15:0] angle);
    return longint'(sine_lut[angle[15:8]]);
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  initial begin
    for (int k = 0; k < SINE_DEPTH_C; k++) sine_lut[k] = quarter_sine(k);
  end

  // One Euler step: derivatives from the old phases, then update, then coherence.
  task automatic predict_step();
    longint deriv[MAX_OSC_C];
    longint acc, inc, cs, sn;
    longint unsigned coh;
    logic [15:0] diff;
    int n;
    osc_report_t rep;
    n = (osc_count > MAX_OSC_C) ? MAX_OSC_C : osc_count;
    coh = 0;
    if (!run_on || n == 0) return;
    if (lock_on) begin
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) begin
          if (i != j) begin
            diff = phase_mem[j] - phase_mem[i];
            acc += longint'($signed(coupling_mem[i * MAX_OSC_C + j])) * sine_at(diff);
          end
        end
        deriv[i] = acc >>> 15;
      end
      for (int i = 0; i < n; i++) begin
        inc = ((deriv[i] * longint'(dt)) * 64'sd2670177 + (64'sd1 <<< 31)) >>> 32;
        phase_mem[i] = phase_mem[i] + inc[15:0];
      end
      if (n >= 2) begin
        cs = 0;
        sn = 0;
        for (int i = 0; i < n; i++) begin
          cs += sine_at(phase_mem[i] + 16'd16384);
          sn += sine_at(phase_mem[i]);
        end
        coh = int_root(longint'(cs * cs) + longint'(sn * sn)) / n;
        if (coh > 64'hFFFF) coh = 64'hFFFF;
      end
    end
    for (int i = 0; i < n; i++) begin
      rep.slot = 4'(i);
      rep.phase = phase_mem[i];
      rep.last = (i + 1 == n);
      rep.coh = rep.last ? coh[15:0] : 16'd0;
      report_queue.push_back(rep);
    end
  endtask

  task automatic predict_request(input logic [1:0] op, input logic [39:0] d);
    logic [3:0] a, b;
    int n;
    a = d[3:0];
    b = d[7:4];
    n = (osc_count > MAX_OSC_C) ? MAX_OSC_C : osc_count;
    case (opcode_t'(op))
      OP_COUPLING: begin
        // Writes outside the count are dropped; both mirrored entries are set.
        if (a < n && b < n) begin
          coupling_mem[a * MAX_OSC_C + b] = d[23:8];
          coupling_mem[b * MAX_OSC_C + a] = d[23:8];
        end
      end
      OP_PHASE: phase_mem[a] = d[39:24];
      OP_STEP: predict_step();
      default: ;
    endcase
  endtask

  task automatic compare_result();
    osc_report_t rep;
    if (report_queue.size() == 0) begin
      $error("unexpected result slot %0d phase %0d", m_tdata[3:0], m_tdata[19:4]);
      failures++;
      return;
    end
    rep = report_queue.pop_front();
    if (m_tdata[3:0] !== rep.slot) begin
      $error("osc_slot expected %0d got %0d", rep.slot, m_tdata[3:0]);
      failures++;
    end
    if (m_tdata[19:4] !== rep.phase) begin
      $error("new_phase expected %0d got %0d", rep.phase, m_tdata[19:4]);
      failures++;
    end
    if (m_tdata[35:20] !== rep.coh) begin
      $error("coherence expected %0d got %0d", rep.coh, m_tdata[35:20]);
      failures++;
    end
    if (m_tlast !== rep.last) begin
      $error("last expected %0d got %0d", rep.last, m_tlast);
      failures++;
    end
  endtask

  initial failures = 0;
  assign pending = report_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_OSC_C; i++) phase_mem[i] = '0;
      for (int i = 0; i < MAX_OSC_C * MAX_OSC_C; i++) coupling_mem[i] = '0;
      osc_count = 5'd0;
      dt = 16'd256;
      run_on = 1'b0;
      lock_on = 1'b0;
      report_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_COUNT: osc_count = cfg_data[4:0];
          CFG_DT:    dt = cfg_data;
          CFG_RUN:   run_on = cfg_data[0];
          CFG_LOCK:  lock_on = cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) compare_result();
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
    end
  end
endmodule

// File: test/testbench.sv
// Top of the testbench: stimulus, idling patterns and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import cpo_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // tdata: first_slot[3:0], second_slot[7:4], coupling_value[23:8], phase_value[39:24]
  logic [39:0] s_tdata;
  // tuser: opcode[1:0]
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // tdata: osc_slot[3:0], new_phase[19:4], coherence[35:20]
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          failures;
  int          pending;

  // Idle percentages of the two sides; the stimulus moves through three settings.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Oscillator count last programmed, so random writes mostly land in range.
  int unsigned cur_count;

  coupled_phase_oscillator_step_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  coupled_phase_oscillator_step_checker step_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The receiver stalls at random with the current percentage.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one request. The sender may idle first; valid stays high when requests
  // follow back to back, so it is never lowered and raised in one time step.
  task automatic send_request(input opcode_t op, input logic [3:0] a, input logic [3:0] b,
                              input logic [15:0] coupling, input logic [15:0] phase);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {phase, coupling, b, a};
    do @(posedge clk); while (!s_tready);
  endtask

  // Lets every pending step drain, plus the longest step latency, so the core is
  // idle before a register changes. This is also where the sender holds off
  // until every expected result has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic program_core(input logic [4:0] count, input logic [15:0] dt,
                              input logic run, input logic lock);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_COUNT;
    cfg_data <= {11'd0, count};
    @(posedge clk);
    cfg_index <= CFG_DT;
    cfg_data <= dt;
    @(posedge clk);
    cfg_index <= CFG_RUN;
    cfg_data <= {15'd0, run};
    @(posedge clk);
    cfg_index <= CFG_LOCK;
    cfg_data <= {15'd0, lock};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_count = (count > MAX_OSC_C) ? MAX_OSC_C : count;
  endtask

  // Picks a random slot, mostly inside the programmed count.
  function automatic logic [3:0] pick_slot();
    if (cur_count > 0 && $urandom_range(9) < 8) return 4'($urandom_range(cur_count - 1));
    return 4'($urandom_range(15));
  endfunction

  // Random traffic: mostly coupling and phase loads followed by steps, with a
  // little noise from the unused opcode and out-of-range coupling writes.
  task automatic random_requests(input int count);
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 35)
        send_request(OP_COUPLING, pick_slot(), pick_slot(), 16'($urandom), 16'($urandom));
      else if (pick < 65)
        send_request(OP_PHASE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     16'($urandom), 16'($urandom));
      else if (pick < 92)
        send_request(OP_STEP, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
      else
        send_request(OP_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_config();
    int unsigned pick;
    logic [4:0] count;
    logic [15:0] dt;
    pick = $urandom_range(9);
    count = (pick < 7) ? 5'($urandom_range(2, 16)) : (pick < 8) ? 5'd16 : 5'($urandom_range(17, 31));
    pick = $urandom_range(9);
    dt = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
    program_core(count, dt, $urandom_range(9) != 0, $urandom_range(9) != 0);
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OP_COUPLING;
    cfg_we <= 1'b0;
    cfg_index <= CFG_COUNT;
    cfg_data <= '0;
    m_tready <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 58;
    cur_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A step before the core runs must give nothing back.
    program_core(5'd4, 16'd256, 1'b0, 1'b0);
    send_request(OP_PHASE, 4'd0, 4'd0, 16'd0, 16'd0);
    send_request(OP_PHASE, 4'd1, 4'd0, 16'd0, 16'hFFFF);
    send_request(OP_PHASE, 4'd2, 4'd0, 16'd0, 16'h4000);
    send_request(OP_PHASE, 4'd15, 4'd0, 16'd0, 16'h8001);
    send_request(OP_COUPLING, 4'd0, 4'd1, 16'h7FFF, 16'd0);
    send_request(OP_COUPLING, 4'd1, 4'd2, 16'h8000, 16'd0);
    send_request(OP_COUPLING, 4'd2, 4'd2, 16'h1234, 16'd0);
    // Index beyond the count: the write is dropped.
    send_request(OP_COUPLING, 4'd3, 4'd15, 16'h7FFF, 16'd0);
    send_request(OP_STEP, 4'd0, 4'd0, 16'd0, 16'd0);
    send_request(OP_UNUSED, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF);
    // Running with phase lock off reports the phases unchanged.
    program_core(5'd4, 16'd256, 1'b1, 1'b0);
    send_request(OP_STEP, 4'd0, 4'd0, 16'd0, 16'd0);
    program_core(5'd4, 16'hFFFF, 1'b1, 1'b1);
    send_request(OP_STEP, 4'd0, 4'd0, 16'd0, 16'd0);
    send_request(OP_STEP, 4'd0, 4'd0, 16'd0, 16'd0);
    // A zero time step leaves the phases where they are.
    program_core(5'd3, 16'd0, 1'b1, 1'b1);
    send_request(OP_STEP, 4'd0, 4'd0, 16'd0, 16'd0);
    // An empty set of oscillators gives no result.
    program_core(5'd0, 16'd256, 1'b1, 1'b1);
    send_request(OP_STEP, 4'd0, 4'd0, 16'd0, 16'd0);
    // Count above the maximum saturates to the full set, with extreme couplings.
    program_core(5'd31, 16'd4096, 1'b1, 1'b1);
    send_request(OP_COUPLING, 4'd15, 4'd0, 16'h7FFF, 16'd0);
    send_request(OP_COUPLING, 4'd14, 4'd15, 16'h8000, 16'd0);
    send_request(OP_PHASE, 4'd14, 4'd0, 16'd0, 16'hC000);
    send_request(OP_STEP, 4'd0, 4'd0, 16'd0, 16'd0);
    // One oscillator alone: the coherence stays zero.
    program_core(5'd1, 16'd256, 1'b1, 1'b1);
    send_request(OP_STEP, 4'd0, 4'd0, 16'd0, 16'd0);

    // Random part over the three idling settings.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 58 : 0;
      recv_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 38 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        random_config();
        random_requests(25);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (failures == 0) begin
      $display("coupled_phase_oscillator_step_core verification clean");
    end else begin
      $display("coupled_phase_oscillator_step_core verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("coupled_phase_oscillator_step_core verification failed");
    $finish;
  end
endmodule
